>>> src/obp_pkg.sv
`timescale 1ns / 1ps
package obp_pkg;

  typedef logic signed [15:0] coef_t;
  typedef logic signed [23:0] center_t;
  typedef logic        [22:0] half_t;
  typedef logic signed [31:0] rn_prod_t;
  typedef logic signed [39:0] nc_prod_t;
  typedef logic signed [33:0] m_acc_t;
  typedef logic signed [41:0] dot_acc_t;
  typedef logic signed [19:0] mvec_t;
  typedef logic signed [28:0] dist_d_t;
  typedef logic signed [43:0] hm_prod_t;
  typedef logic        [30:0] radius_t;
  typedef logic signed [32:0] dist_wide_t;
  typedef logic signed [27:0] dist_t;

  localparam dist_wide_t DIST_MAX = 33'sd134217727;
  localparam dist_wide_t DIST_MIN = -33'sd134217728;

  localparam coef_t   NORMAL_X_RESET = 16'sd0;
  localparam coef_t   NORMAL_Y_RESET = 16'sd0;
  localparam coef_t   NORMAL_Z_RESET = 16'sd16384;
  localparam center_t OFFSET_RESET   = 24'sd0;

  typedef enum logic [1:0] {
    SIDE_CROSS  = 2'd0,
    SIDE_BEHIND = 2'd1,
    SIDE_FRONT  = 2'd2
  } side_t;

  typedef enum logic [1:0] {
    CFG_NORMAL_X     = 2'd0,
    CFG_NORMAL_Y     = 2'd1,
    CFG_NORMAL_Z     = 2'd2,
    CFG_PLANE_OFFSET = 2'd3
  } cfg_idx_t;

  // rn index is 3*row + column
  typedef struct packed {
    logic                 valid;
    rn_prod_t [8:0]       rn;
    nc_prod_t [2:0]       nc;
    half_t    [2:0]       half;
  } mul_beat_t;

  typedef struct packed {
    logic                 valid;
    mvec_t    [2:0]       m;
    dist_d_t              d;
    half_t    [2:0]       half;
  } sum_beat_t;

  typedef struct packed {
    logic                 valid;
    radius_t              r;
    dist_d_t              d;
  } rad_beat_t;

endpackage

>>> src/obp_mul.sv
`timescale 1ns / 1ps
module obp_mul (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [2:0][47:0]           rot,
  input  obp_pkg::center_t [2:0]     center,
  input  obp_pkg::half_t   [2:0]     half,
  input  obp_pkg::coef_t   [2:0]     normal,
  output obp_pkg::mul_beat_t         beat
);

  obp_pkg::rn_prod_t [8:0] rn_c;
  obp_pkg::nc_prod_t [2:0] nc_c;

  // Form every rotation-times-normal product and the normal-times-center products.
  always_comb begin
    obp_pkg::coef_t ent;
    obp_pkg::coef_t nrm;
    obp_pkg::center_t ctr;
    for (int i = 0; i < 3; i++) begin
      nrm = normal[i];
      ctr = center[i];
      for (int j = 0; j < 3; j++) begin
        ent = rot[i][16*j +: 16];
        rn_c[3*i+j] = ent * nrm;
      end
      nc_c[i] = nrm * ctr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat.valid <= 1'b0;
    end else begin
      beat.valid <= in_valid;
    end
    beat.rn   <= rn_c;
    beat.nc   <= nc_c;
    beat.half <= half;
  end

endmodule

>>> src/obp_sum.sv
`timescale 1ns / 1ps
module obp_sum (
  input  logic                clk,
  input  logic                rst,
  input  obp_pkg::mul_beat_t  in_beat,
  input  obp_pkg::center_t    plane_offset,
  output obp_pkg::sum_beat_t  beat
);

  obp_pkg::mvec_t [2:0] m_c;
  obp_pkg::dist_d_t     d_c;

  // Sum the columns, floor by 2^14, and take the center distance.
  always_comb begin
    obp_pkg::m_acc_t   acc;
    obp_pkg::dot_acc_t dot;
    for (int j = 0; j < 3; j++) begin
      acc = obp_pkg::m_acc_t'($signed(in_beat.rn[j]))
          + obp_pkg::m_acc_t'($signed(in_beat.rn[3+j]))
          + obp_pkg::m_acc_t'($signed(in_beat.rn[6+j]));
      m_c[j] = acc[33:14];
    end
    dot = obp_pkg::dot_acc_t'($signed(in_beat.nc[0]))
        + obp_pkg::dot_acc_t'($signed(in_beat.nc[1]))
        + obp_pkg::dot_acc_t'($signed(in_beat.nc[2]));
    d_c = obp_pkg::dist_d_t'($signed(dot[41:14]))
        - obp_pkg::dist_d_t'(plane_offset);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat.valid <= 1'b0;
    end else begin
      beat.valid <= in_beat.valid;
    end
    beat.m    <= m_c;
    beat.d    <= d_c;
    beat.half <= in_beat.half;
  end

endmodule

>>> src/obp_radius.sv
`timescale 1ns / 1ps
module obp_radius (
  input  logic                clk,
  input  logic                rst,
  input  obp_pkg::sum_beat_t  in_beat,
  output obp_pkg::rad_beat_t  beat
);

  obp_pkg::hm_prod_t [2:0] hm_c;
  obp_pkg::hm_prod_t [2:0] hm;
  obp_pkg::dist_d_t        hm_d;
  logic                    hm_valid;
  obp_pkg::radius_t        r_c;

  // Extent times rotated normal, one multiplier per axis.
  always_comb begin
    obp_pkg::hm_prod_t h_ext;
    obp_pkg::hm_prod_t m_ext;
    for (int j = 0; j < 3; j++) begin
      h_ext   = obp_pkg::hm_prod_t'({1'b0, in_beat.half[j]});
      m_ext   = obp_pkg::hm_prod_t'($signed(in_beat.m[j]));
      hm_c[j] = h_ext * m_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hm_valid <= 1'b0;
    end else begin
      hm_valid <= in_beat.valid;
    end
  end

  always_ff @(posedge clk) begin
    hm   <= hm_c;
    hm_d <= in_beat.d;
  end

  // Truncate each magnitude by 2^14 to whole units (Q.0) and add.
  always_comb begin
    obp_pkg::hm_prod_t mag;
    r_c = '0;
    for (int j = 0; j < 3; j++) begin
      mag = (hm[j] < 0) ? -hm[j] : hm[j];
      r_c = r_c + obp_pkg::radius_t'(mag[42:14]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat.valid <= 1'b0;
    end else begin
      beat.valid <= hm_valid;
    end
    beat.r <= r_c;
    beat.d <= hm_d;
  end

endmodule

>>> src/obp_classify.sv
`timescale 1ns / 1ps
module obp_classify (
  input  logic                clk,
  input  logic                rst,
  input  obp_pkg::rad_beat_t  in_beat,
  output logic                done,
  output obp_pkg::dist_t      distance,
  output obp_pkg::side_t      side
);

  obp_pkg::dist_t distance_next;
  obp_pkg::side_t side_next;

  always_comb begin
    obp_pkg::dist_wide_t dw;
    obp_pkg::dist_wide_t rw;
    obp_pkg::dist_wide_t ad;
    obp_pkg::dist_wide_t gap;
    dw = obp_pkg::dist_wide_t'(in_beat.d);
    rw = obp_pkg::dist_wide_t'({1'b0, in_beat.r});
    ad = (dw < 0) ? -dw : dw;
    if (ad < rw) begin
      gap       = '0;
      side_next = obp_pkg::SIDE_CROSS;
    end else if (dw < 0) begin
      gap       = dw + rw;
      side_next = obp_pkg::SIDE_BEHIND;
    end else begin
      gap       = dw - rw;
      side_next = obp_pkg::SIDE_FRONT;
    end
    if (gap > obp_pkg::DIST_MAX) begin
      gap = obp_pkg::DIST_MAX;
    end else if (gap < obp_pkg::DIST_MIN) begin
      gap = obp_pkg::DIST_MIN;
    end
    distance_next = gap[27:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_beat.valid;
    end
  end

  always_ff @(posedge clk) begin
    distance <= distance_next;
    side     <= side_next;
  end

endmodule

>>> src/obb_plane_distance_top.sv
`timescale 1ns / 1ps
// A box passes through the multiply, sum, extent-product, radius and classify registers,
// in that order, before done/distance/side show its result.
// Throughput: one box per cycle; busy stays low and start may be high every cycle,
// since every stage advances each cycle and nothing downstream pushes back.
// Reset (rst, synchronous, active high) clears all stage valid bits and loads the
// plane registers with normal (0, 0, 1.0) and offset 0; the receiver cannot stall.
module obb_plane_distance_top (
  input  logic                       clk,
  input  logic                       rst,
  // box channel
  input  logic                       start,
  output logic                       busy,
  input  logic signed [23:0]         center_x,
  input  logic signed [23:0]         center_y,
  input  logic signed [23:0]         center_z,
  input  logic [47:0]                rot_row0,
  input  logic [47:0]                rot_row1,
  input  logic [47:0]                rot_row2,
  input  logic [22:0]                half_x,
  input  logic [22:0]                half_y,
  input  logic [22:0]                half_z,
  // result channel
  output logic                       done,
  output logic signed [27:0]         distance,
  output logic [1:0]                 side,
  // configuration channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [23:0]                cfg_data
);

  obp_pkg::coef_t [2:0]  normal;
  obp_pkg::center_t      plane_offset;

  obp_pkg::mul_beat_t    mul_beat;
  obp_pkg::sum_beat_t    sum_beat;
  obp_pkg::rad_beat_t    rad_beat;
  obp_pkg::side_t        side_q;
  obp_pkg::dist_t        distance_q;

  // Every stage advances each cycle and nothing downstream can push back,
  // so a new box is taken on every cycle.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Plane registers. Normal entries take the low 16 bits of the beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      normal[0]    <= obp_pkg::NORMAL_X_RESET;
      normal[1]    <= obp_pkg::NORMAL_Y_RESET;
      normal[2]    <= obp_pkg::NORMAL_Z_RESET;
      plane_offset <= obp_pkg::OFFSET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (obp_pkg::cfg_idx_t'(cfg_index))
        obp_pkg::CFG_NORMAL_X:     normal[0]    <= cfg_data[15:0];
        obp_pkg::CFG_NORMAL_Y:     normal[1]    <= cfg_data[15:0];
        obp_pkg::CFG_NORMAL_Z:     normal[2]    <= cfg_data[15:0];
        obp_pkg::CFG_PLANE_OFFSET: plane_offset <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Stage 1: all products of the normal with the rotation rows and the center.
  obp_mul u_mul (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .rot      ({rot_row2, rot_row1, rot_row0}),
    .center   ({center_z, center_y, center_x}),
    .half     ({half_z, half_y, half_x}),
    .normal   (normal),
    .beat     (mul_beat)
  );

  // Stage 2: rotated normal m = R^T n and center distance d = n.c - offset.
  obp_sum u_sum (
    .clk          (clk),
    .rst          (rst),
    .in_beat      (mul_beat),
    .plane_offset (plane_offset),
    .beat         (sum_beat)
  );

  // Stages 3 and 4: extent products, then the projected radius.
  obp_radius u_radius (
    .clk     (clk),
    .rst     (rst),
    .in_beat (sum_beat),
    .beat    (rad_beat)
  );

  // Stage 5: compare |d| with r, form the gap, saturate, hold the result beat.
  obp_classify u_classify (
    .clk      (clk),
    .rst      (rst),
    .in_beat  (rad_beat),
    .done     (done),
    .distance (distance_q),
    .side     (side_q)
  );

  assign distance = distance_q;
  assign side     = side_q;

`ifndef ASSERT_OFF
  // A result beat always traces back to a box taken on the box channel.
  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 5))
    else $error("result beat without a matching box");

  // A crossing box reports zero gap.
  a_cross_zero: assert property (@(posedge clk) disable iff (rst)
    (done && side_q == obp_pkg::SIDE_CROSS) |-> (distance == 28'sd0))
    else $error("crossing box with nonzero distance");

  // A box in front never reports a negative gap, one behind never a positive one.
  a_sign_matches_side: assert property (@(posedge clk) disable iff (rst)
    done |-> ((side_q == obp_pkg::SIDE_FRONT && !distance[27]) ||
              (side_q == obp_pkg::SIDE_BEHIND && (distance[27] || distance == 28'sd0)) ||
              side_q == obp_pkg::SIDE_CROSS))
    else $error("distance sign disagrees with side");
`endif

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;

  // Pipeline depth of the block, used to pad the drain waits.
  localparam int LATENCY    = 5;
  localparam int PHASES     = 8;
  localparam int PHASE_BOXES = 175;

  // One box as it travels on the box channel.
  typedef struct packed {
    obp_pkg::center_t [2:0] c;
    logic [2:0][47:0]       row;
    obp_pkg::half_t   [2:0] h;
  } box_t;

  // Expected gap result for one box.
  typedef struct packed {
    obp_pkg::dist_t distance;
    obp_pkg::side_t side;
  } gap_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic signed [23:0] center_x = '0;
  logic signed [23:0] center_y = '0;
  logic signed [23:0] center_z = '0;
  logic [47:0]       rot_row0 = '0;
  logic [47:0]       rot_row1 = '0;
  logic [47:0]       rot_row2 = '0;
  logic [22:0]       half_x = '0;
  logic [22:0]       half_y = '0;
  logic [22:0]       half_z = '0;
  logic              done;
  logic signed [27:0] distance;
  logic [1:0]        side;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = '0;
  logic [23:0]       cfg_data = '0;

  obb_plane_distance_top dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .center_x  (center_x),
    .center_y  (center_y),
    .center_z  (center_z),
    .rot_row0  (rot_row0),
    .rot_row1  (rot_row1),
    .rot_row2  (rot_row2),
    .half_x    (half_x),
    .half_y    (half_y),
    .half_z    (half_z),
    .done      (done),
    .distance  (distance),
    .side      (side),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Plane registers as the block should hold them; start from reset values.
  obp_pkg::coef_t   plane_nx  = obp_pkg::NORMAL_X_RESET;
  obp_pkg::coef_t   plane_ny  = obp_pkg::NORMAL_Y_RESET;
  obp_pkg::coef_t   plane_nz  = obp_pkg::NORMAL_Z_RESET;
  obp_pkg::center_t plane_off = obp_pkg::OFFSET_RESET;

  box_t pending_boxes[$];   // boxes waiting for the driver
  gap_t expected_gaps[$];   // gaps owed by the block, oldest first
  int   fault_count = 0;
  int   boxes_sent  = 0;
  bit   box_taken   = 1'b0; // the beat on the box channel was taken at the last edge

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Signed gap between box and plane, computed from the held plane registers.
  function automatic gap_t plane_gap(box_t b);
    longint nv[3];
    longint acc, m, prod, radius, dot, d, gap_len;
    gap_t   g;
    nv[0] = plane_nx;
    nv[1] = plane_ny;
    nv[2] = plane_nz;
    radius = 0;
    dot = 0;
    // Rotate the normal into box space column by column, then project extents.
    for (int j = 0; j < 3; j++) begin
      acc = 0;
      for (int i = 0; i < 3; i++)
        acc += longint'(signed'(b.row[i][16*j +: 16])) * nv[i];
      m = acc >>> 14;
      prod = longint'(b.h[j]) * m;
      if (prod < 0)
        prod = -prod;
      radius += prod >>> 14;
    end
    for (int i = 0; i < 3; i++)
      dot += longint'(signed'(b.c[i])) * nv[i];
    d = (dot >>> 14) - longint'(plane_off);
    // Touching exactly counts as not crossing; d == r == 0 lands in front.
    if ((d < 0 ? -d : d) < radius) begin
      gap_len = 0;
      g.side = obp_pkg::SIDE_CROSS;
    end else if (d < 0) begin
      gap_len = d + radius;
      g.side = obp_pkg::SIDE_BEHIND;
    end else begin
      gap_len = d - radius;
      g.side = obp_pkg::SIDE_FRONT;
    end
    // Clamp to the output range.
    if (gap_len > longint'(obp_pkg::DIST_MAX))
      gap_len = longint'(obp_pkg::DIST_MAX);
    if (gap_len < longint'(obp_pkg::DIST_MIN))
      gap_len = longint'(obp_pkg::DIST_MIN);
    g.distance = obp_pkg::dist_t'(gap_len);
    return g;
  endfunction

  function automatic box_t make_box(obp_pkg::center_t cx, obp_pkg::center_t cy,
                                    obp_pkg::center_t cz,
                                    logic [47:0] r0, logic [47:0] r1, logic [47:0] r2,
                                    obp_pkg::half_t hx, obp_pkg::half_t hy,
                                    obp_pkg::half_t hz);
    box_t b;
    b.c   = {cz, cy, cx};
    b.row = {r2, r1, r0};
    b.h   = {hz, hy, hx};
    return b;
  endfunction

  // Corner boxes of the field ranges: all zero, all ones, most positive, most negative.
  function automatic box_t extreme_box(int kind);
    box_t b;
    case (kind)
      0: b = '0;
      1: b = '1;
      2: b = make_box(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, {3{16'h7FFF}},
                      {3{16'h7FFF}}, {3{16'h7FFF}}, '1, '1, '1);
      default: b = make_box(24'h800000, 24'h800000, 24'h800000, {3{16'h8000}},
                            {3{16'h8000}}, {3{16'h8000}}, '1, '1, '1);
    endcase
    return b;
  endfunction

  // Mostly plausible boxes near the plane so every side shows; some raw bit noise.
  function automatic box_t rand_box();
    box_t b;
    int   kind;
    kind = $urandom_range(0, 9);
    if (kind < 3) begin
      for (int i = 0; i < 3; i++) begin
        b.c[i]   = obp_pkg::center_t'($urandom);
        b.row[i] = {16'($urandom), 32'($urandom)};
        b.h[i]   = obp_pkg::half_t'($urandom);
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        b.c[i] = obp_pkg::center_t'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
        for (int j = 0; j < 3; j++)
          b.row[i][16*j +: 16] = 16'(int'($urandom_range(0, 32768)) - 16384);
        b.h[i] = obp_pkg::half_t'($urandom_range(0, 1 << 16));
      end
    end
    return b;
  endfunction

  // Write one plane register; normal writes carry random junk above bit 15.
  task automatic write_reg(input obp_pkg::cfg_idx_t idx, input logic [23:0] value);
    logic [7:0] pad;
    pad = $urandom;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= (idx == obp_pkg::CFG_PLANE_OFFSET) ? value : {pad, value[15:0]};
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      obp_pkg::CFG_NORMAL_X: plane_nx  = obp_pkg::coef_t'(value[15:0]);
      obp_pkg::CFG_NORMAL_Y: plane_ny  = obp_pkg::coef_t'(value[15:0]);
      obp_pkg::CFG_NORMAL_Z: plane_nz  = obp_pkg::coef_t'(value[15:0]);
      default:               plane_off = obp_pkg::center_t'(value);
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_index <= 2'($urandom);
    cfg_data  <= 24'($urandom);
  endtask

  // Hold until every box has gone through and the pipeline has emptied.
  task automatic wait_drained();
    while (pending_boxes.size() != 0 || expected_gaps.size() != 0 || start)
      @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // Box driver: advance on a taken beat, hold while busy, idle now and then.
  // Every few hundred beats, run a stretch with no idling at all.
  always @(negedge clk) begin
    box_t b;
    bit   quiet;
    if (!rst && (!start || box_taken)) begin
      quiet = (boxes_sent % 600) >= 380;
      if (pending_boxes.size() != 0 && (quiet || $urandom_range(0, 99) >= 6)) begin
        b = pending_boxes.pop_front();
        center_x <= b.c[0];
        center_y <= b.c[1];
        center_z <= b.c[2];
        rot_row0 <= b.row[0];
        rot_row1 <= b.row[1];
        rot_row2 <= b.row[2];
        half_x   <= b.h[0];
        half_y   <= b.h[1];
        half_z   <= b.h[2];
        start    <= 1'b1;
        boxes_sent++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check the result strobe first, then record a newly taken box,
  // so a result never pairs with the box taken at the same edge.
  always @(posedge clk) begin
    box_t seen;
    gap_t want;
    box_taken = 1'b0;
    if (!rst) begin
      if (done === 1'b1) begin
        if (expected_gaps.size() == 0) begin
          fault_count++;
          $display("%0t unexpected result: expected none actual distance %0d side %0d",
                   $time, distance, side);
        end else begin
          want = expected_gaps.pop_front();
          if (distance !== want.distance) begin
            fault_count++;
            $display("%0t distance mismatch: expected %0d actual %0d",
                     $time, want.distance, distance);
          end
          if (side !== want.side) begin
            fault_count++;
            $display("%0t side mismatch: expected %0d actual %0d",
                     $time, want.side, side);
          end
        end
      end else if (done !== 1'b0) begin
        fault_count++;
        $display("%0t done unknown: expected 0 or 1 actual %b", $time, done);
      end
      if (start && !busy) begin
        seen.c   = {center_z, center_y, center_x};
        seen.row = {rot_row2, rot_row1, rot_row0};
        seen.h   = {half_z, half_y, half_x};
        expected_gaps.push_back(plane_gap(seen));
        box_taken = 1'b1;
      end
    end
  end

  // Stimulus: directed boxes on the reset plane, then phases of random boxes,
  // each phase after the first under a new plane written while the block is idle.
  initial begin
    logic [15:0] nx, ny, nz;
    logic [23:0] off;
    logic [47:0] id0, id1, id2;
    id0 = 48'h0000_0000_4000;
    id1 = 48'h0000_4000_0000;
    id2 = 48'h4000_0000_0000;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset plane is z = 0 facing +z, so an identity box gives d = cz, r = hz.
    pending_boxes.push_back(make_box(0, 0, 0, id0, id1, id2, 0, 0, 0));
    pending_boxes.push_back(make_box(7, -9, 100, id0, id1, id2, 5, 5, 100));
    pending_boxes.push_back(make_box(3, 3, -100, id0, id1, id2, 5, 5, 100));
    pending_boxes.push_back(make_box(0, 0, 50, id0, id1, id2, 1, 1, 100));
    pending_boxes.push_back(make_box(0, 0, -50, id0, id1, id2, 1, 1, 100));
    pending_boxes.push_back(make_box(0, 0, 1000, id0, id1, id2, 1, 1, 100));
    pending_boxes.push_back(make_box(0, 0, -1000, id0, id1, id2, 1, 1, 100));
    pending_boxes.push_back(make_box(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, '0, '0, '0, 0, 0, 0));
    pending_boxes.push_back(make_box(24'h800000, 24'h800000, 24'h800000, '0, '0, '0, 0, 0, 0));
    pending_boxes.push_back(make_box(0, 0, 24'h7FFFFF, id0, id1, id2, '1, '1, '1));
    pending_boxes.push_back(make_box(0, 0, 24'h800000, id0, id1, id2, '1, '1, '1));
    // Non-orthonormal rotation: every entry at 1.0.
    pending_boxes.push_back(make_box(1234, -5678, 4321, {3{16'h4000}}, {3{16'h4000}},
                                     {3{16'h4000}}, 300, 200, 100));
    pending_boxes.push_back(make_box(24'h123456, 24'hFEDCBA, 24'h0F0F0F, '1, '1, '1,
                                     '1, '1, '1));
    pending_boxes.push_back(make_box(-77, 77, -3, {3{16'h8000}}, {3{16'h7FFF}},
                                     {3{16'h8000}}, 23'h2AAAAA, 23'h555555, 23'h7FFFFF));

    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        wait_drained();
        case (p)
          1: begin
            nx = 16'd16384; ny = 16'd0; nz = 16'd0; off = 24'd0;
          end
          2: begin
            nx = -16'sd16384; ny = -16'sd16384; nz = -16'sd16384; off = 24'h7FFFFF;
          end
          3: begin
            nx = 16'd16384; ny = 16'd16384; nz = 16'd16384; off = 24'h800000;
          end
          4: begin
            // Full field extremes, well outside a unit normal.
            nx = 16'h8000; ny = 16'h7FFF; nz = 16'h0000; off = 24'($urandom);
          end
          default: begin
            nx = 16'(int'($urandom_range(0, 32768)) - 16384);
            ny = 16'(int'($urandom_range(0, 32768)) - 16384);
            nz = 16'(int'($urandom_range(0, 32768)) - 16384);
            off = 24'(int'($urandom_range(0, 1 << 17)) - (1 << 16));
          end
        endcase
        write_reg(obp_pkg::CFG_NORMAL_X, {8'h00, nx});
        write_reg(obp_pkg::CFG_NORMAL_Y, {8'h00, ny});
        write_reg(obp_pkg::CFG_NORMAL_Z, {8'h00, nz});
        write_reg(obp_pkg::CFG_PLANE_OFFSET, off);
      end
      for (int k = 0; k < 4; k++)
        pending_boxes.push_back(extreme_box(k));
      repeat (PHASE_BOXES) pending_boxes.push_back(rand_box());
    end

    wait_drained();
    repeat (LATENCY * 4) @(posedge clk);
    if (fault_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #400000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> obb_plane_distance_top.f
src/obp_pkg.sv
src/obp_mul.sv
src/obp_sum.sv
src/obp_radius.sv
src/obp_classify.sv
src/obb_plane_distance_top.sv
tb/tb.sv
